>>> design/egr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package egr_pkg;

  localparam int unsigned MAX_VERTICES = 32;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned VW     = 5;
  localparam int unsigned RW     = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned DEG_W  = 5;
  localparam int unsigned FILL_W = 9;
  localparam int unsigned CNT_W  = 6;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ELIM    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_DEAD  = 2'd2;

  typedef struct packed {
    logic capture;
    logic open;
    logic step;
    logic finish_elim;
    logic finish_simple;
  } egr_cmd_t;

  typedef struct packed {
    logic elim_ok;
    logic last;
  } egr_sts_t;

endpackage
`default_nettype wire

>>> design/elimination_game_replay.sv
`timescale 1ns / 1ps
`default_nettype none
// Vertex elimination replay engine. An item is taken when start_i is high and
// busy_o is low; its single result appears for one cycle with done_o high,
// and the receiver cannot stall it. Load, restart, unused opcodes and rejected
// eliminations go from the idle state through the execute state back to idle. A valid
// eliminate adds a sweep over min(MaxVertices, 32) rows and a finish state:
// the sweep reads and counts missing pairs in one adjacency row per cycle
// and rewrites each neighbor's row via the row store's single write port.
// The result strobe falls in the first cycle that busy_o is low again.
// vertex_count sits at byte address 0 of the register port and resets to 32.
module elimination_game_replay #(
  parameter int unsigned MaxVertices = egr_pkg::MAX_VERTICES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [egr_pkg::OP_W-1:0]    opcode_i,
  input  wire logic [egr_pkg::VW-1:0]      vertex_i,
  input  wire logic [egr_pkg::RW-1:0]      row_bits_i,
  output logic                             done_o,
  output logic [egr_pkg::ST_W-1:0]         status_o,
  output logic [egr_pkg::DEG_W-1:0]        degree_o,
  output logic [egr_pkg::RW-1:0]           bag_mask_o,
  output logic [egr_pkg::FILL_W-1:0]       fill_count_o,
  output logic [egr_pkg::DEG_W-1:0]        max_degree_o,
  output logic [egr_pkg::FILL_W-1:0]       total_fill_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam logic RegVertexCount = 1'b0;

  egr_pkg::egr_cmd_t cmd;
  egr_pkg::egr_sts_t sts;
  logic                        cfg_hit;
  logic                        cfg_we;
  logic [egr_pkg::CNT_W-1:0]   vertex_count;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == RegVertexCount);
  assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? 32'(vertex_count) : '0;

  egr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  egr_datapath #(
    .MaxVertices(MaxVertices)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .vertex_i      (vertex_i),
    .row_bits_i    (row_bits_i),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[egr_pkg::CNT_W-1:0]),
    .vertex_count_o(vertex_count),
    .status_o      (status_o),
    .degree_o      (degree_o),
    .bag_mask_o    (bag_mask_o),
    .fill_count_o  (fill_count_o),
    .max_degree_o  (max_degree_o),
    .total_fill_o  (total_fill_o)
  );

endmodule
`default_nettype wire

>>> design/egr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module egr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire egr_pkg::egr_sts_t sts_i,
  output egr_pkg::egr_cmd_t      cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.capture = start_i;
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.elim_ok) begin
          cmd_o.open = 1'b1;
          state_d = S_SWEEP;
        end else begin
          cmd_o.finish_simple = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish_elim = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    done_d = cmd_o.finish_simple | cmd_o.finish_elim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_EXEC))
    else $error("accepted transaction did not enter execution");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_EXEC || $past(state_q) == S_FINISH))
    else $error("result strobe without a finishing state");

endmodule
`default_nettype wire

>>> design/egr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module egr_datapath #(
  parameter int unsigned MaxVertices = egr_pkg::MAX_VERTICES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire egr_pkg::egr_cmd_t           cmd_i,
  output egr_pkg::egr_sts_t                sts_o,
  input  wire logic [egr_pkg::OP_W-1:0]    opcode_i,
  input  wire logic [egr_pkg::VW-1:0]      vertex_i,
  input  wire logic [egr_pkg::RW-1:0]      row_bits_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [egr_pkg::CNT_W-1:0]   cfg_wdata_i,
  output logic [egr_pkg::CNT_W-1:0]        vertex_count_o,
  output logic [egr_pkg::ST_W-1:0]         status_o,
  output logic [egr_pkg::DEG_W-1:0]        degree_o,
  output logic [egr_pkg::RW-1:0]           bag_mask_o,
  output logic [egr_pkg::FILL_W-1:0]       fill_count_o,
  output logic [egr_pkg::DEG_W-1:0]        max_degree_o,
  output logic [egr_pkg::FILL_W-1:0]       total_fill_o
);

  localparam int unsigned RW     = egr_pkg::RW;
  localparam int unsigned VW     = egr_pkg::VW;
  localparam int unsigned CNT_W  = egr_pkg::CNT_W;
  localparam int unsigned DEG_W  = egr_pkg::DEG_W;
  localparam int unsigned FILL_W = egr_pkg::FILL_W;
  localparam int unsigned Rows   = (MaxVertices < RW) ? MaxVertices : RW;
  localparam int unsigned IdxW   = $clog2(Rows);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Rows - 1);
  localparam logic [DEG_W-1:0] DegMax = '1;
  localparam logic [FILL_W-1:0] FillMax = '1;

  function automatic logic [CNT_W-1:0] popcount(input logic [RW-1:0] x);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < RW; i++) begin
      c = c + CNT_W'(x[i]);
    end
    return c;
  endfunction

  logic [RW-1:0]          adj_q [Rows];
  logic [RW-1:0]          alive_q;
  logic [DEG_W-1:0]       width_q;
  logic [FILL_W-1:0]      total_q;
  logic [CNT_W-1:0]       vc_q;
  logic [egr_pkg::OP_W-1:0] op_q;
  logic [VW-1:0]          vertex_q;
  logic [RW-1:0]          row_q;
  logic [RW-1:0]          nb_q;
  logic [DEG_W-1:0]       deg_q;
  logic [FILL_W-1:0]      fill_q;
  logic [IdxW-1:0]        idx_q;

  logic [CNT_W-1:0]       n;
  logic [RW-1:0]          used;
  logic                   in_range;
  logic [IdxW-1:0]        vidx;
  logic [RW-1:0]          self;
  logic [RW-1:0]          nb_new;
  logic [CNT_W-1:0]       deg_cnt;
  logic [VW-1:0]          aidx;
  logic [RW-1:0]          row_a;
  logic [RW-1:0]          above;
  logic [CNT_W-1:0]       miss;
  logic [DEG_W-1:0]       width_new;
  logic [FILL_W:0]        tsum;
  logic [FILL_W-1:0]      total_new;
  logic                   adj_we;
  logic [IdxW-1:0]        adj_waddr;
  logic [RW-1:0]          adj_wdata;

  always_comb begin
    n = (vc_q > CNT_W'(Rows)) ? CNT_W'(Rows) : vc_q;
    for (int u = 0; u < RW; u++) begin
      used[u] = (CNT_W'(u) < n);
    end
    in_range = ({1'b0, vertex_q} < n);
    vidx     = vertex_q[IdxW-1:0];
    self     = RW'(1) << vertex_q;
    nb_new   = adj_q[vidx] & alive_q & used & ~self;
    deg_cnt  = popcount(nb_new);

    // Each neighbor pair is tested once, in the row of its lower vertex.
    aidx  = VW'(idx_q);
    row_a = adj_q[idx_q];
    for (int u = 0; u < RW; u++) begin
      above[u] = nb_q[u] & (VW'(u) > aidx);
    end
    miss = popcount(above & ~row_a);

    width_new = (deg_q > width_q) ? deg_q : width_q;
    tsum      = {1'b0, total_q} + {1'b0, fill_q};
    total_new = tsum[FILL_W] ? FillMax : tsum[FILL_W-1:0];

    adj_we    = 1'b0;
    adj_waddr = idx_q;
    adj_wdata = row_a | (nb_q & ~(RW'(1) << aidx));
    if (cmd_i.step) begin
      adj_we = nb_q[aidx];
    end else if (cmd_i.finish_simple && op_q == egr_pkg::OP_LOAD && in_range) begin
      adj_we    = 1'b1;
      adj_waddr = vidx;
      adj_wdata = row_q & used;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Rows; r++) begin
        adj_q[r] <= '0;
      end
    end else if (adj_we) begin
      adj_q[adj_waddr] <= adj_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
      width_q <= '0;
      total_q <= '0;
      vc_q    <= CNT_W'(32);
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      if (cmd_i.finish_simple) begin
        if (op_q == egr_pkg::OP_LOAD && in_range) begin
          alive_q[vertex_q] <= 1'b1;
        end else if (op_q == egr_pkg::OP_RESTART) begin
          alive_q <= '1;
          width_q <= '0;
          total_q <= '0;
        end
      end
      if (cmd_i.finish_elim) begin
        alive_q[vertex_q] <= 1'b0;
        width_q <= width_new;
        total_q <= total_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= opcode_i;
      vertex_q <= vertex_i;
      row_q    <= row_bits_i;
    end
    if (cmd_i.open) begin
      nb_q   <= nb_new;
      deg_q  <= (deg_cnt > CNT_W'(DegMax)) ? DegMax : deg_cnt[DEG_W-1:0];
      fill_q <= '0;
      idx_q  <= '0;
    end
    if (cmd_i.step) begin
      idx_q <= idx_q + IdxW'(1);
      if (nb_q[aidx]) begin
        fill_q <= fill_q + FILL_W'(miss);
      end
    end
    if (cmd_i.finish_simple) begin
      degree_o     <= '0;
      bag_mask_o   <= '0;
      fill_count_o <= '0;
      case (op_q)
        egr_pkg::OP_LOAD: begin
          status_o     <= in_range ? egr_pkg::ST_OK : egr_pkg::ST_RANGE;
          max_degree_o <= width_q;
          total_fill_o <= total_q;
        end
        egr_pkg::OP_ELIM: begin
          status_o     <= in_range ? egr_pkg::ST_DEAD : egr_pkg::ST_RANGE;
          max_degree_o <= width_q;
          total_fill_o <= total_q;
        end
        egr_pkg::OP_RESTART: begin
          status_o     <= egr_pkg::ST_OK;
          max_degree_o <= '0;
          total_fill_o <= '0;
        end
        default: begin
          status_o     <= egr_pkg::ST_OK;
          max_degree_o <= width_q;
          total_fill_o <= total_q;
        end
      endcase
    end
    if (cmd_i.finish_elim) begin
      status_o     <= egr_pkg::ST_OK;
      degree_o     <= deg_q;
      bag_mask_o   <= nb_q | self;
      fill_count_o <= fill_q;
      max_degree_o <= width_new;
      total_fill_o <= total_new;
    end
  end

  assign sts_o.elim_ok   = (op_q == egr_pkg::OP_ELIM) && in_range && alive_q[vertex_q];
  assign sts_o.last      = (idx_q == LastIdx);
  assign vertex_count_o  = vc_q;

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.capture, cmd_i.open, cmd_i.step, cmd_i.finish_elim, cmd_i.finish_simple}))
    else $error("controller issued more than one command");

  a_sweep_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.open |=> (idx_q == '0))
    else $error("neighbor sweep did not start at row zero");

  a_vertex_dies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_elim |=> !alive_q[vertex_q])
    else $error("eliminated vertex is still alive");

endmodule
`default_nettype wire
